@@ hw/rtl/nps_pkg.sv @@
// Types, constants and the control store of the priority scheduler.
// Used by nonpreemptive_priority_scheduler. No dependencies.
`default_nettype none

package nps_pkg;

  // Fixed field widths
  localparam int ARR_W     = 12;
  localparam int BURST_W   = 12;
  localparam int PRIO_IN_W = 8;
  localparam int JOBNUM_W  = 5;
  localparam int TIME_W    = 17;
  localparam int TOTAL_W   = 21;
  localparam int SENT_W    = 15;

  // Selection start value, above every legal priority
  localparam logic [SENT_W-1:0] PRIO_SENTINEL = 15'd32767;

  // Sequencer steps (control store addresses)
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_SCAN,
    ST_PICK,
    ST_RPT_RD,
    ST_RPT_DIFF,
    ST_RPT_EMIT
  } step_t;

  // Datapath operation of one control word
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_PICK,
    OP_RPT_RD,
    OP_RPT_DIFF,
    OP_RPT_EMIT
  } op_t;

  // Jump condition
  typedef enum logic [1:0] {
    C_ALWAYS,
    C_LOAD_LAST,
    C_ALL_DONE,
    C_IDX_LAST
  } cond_t;

  // One control word
  typedef struct packed {
    logic  busy;
    op_t   op;
    cond_t cond;
    step_t jmp_taken;
    step_t jmp_else;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      ST_IDLE:     w = '{1'b0, OP_LOAD,      C_LOAD_LAST, ST_SCHED,   ST_IDLE};
      ST_SCHED:    w = '{1'b1, OP_SCAN_INIT, C_ALL_DONE,  ST_RPT_RD,  ST_SCAN};
      ST_SCAN:     w = '{1'b1, OP_SCAN,      C_IDX_LAST,  ST_PICK,    ST_SCAN};
      ST_PICK:     w = '{1'b1, OP_PICK,      C_ALWAYS,    ST_SCHED,   ST_SCHED};
      ST_RPT_RD:   w = '{1'b1, OP_RPT_RD,    C_ALWAYS,    ST_RPT_DIFF, ST_RPT_DIFF};
      ST_RPT_DIFF: w = '{1'b1, OP_RPT_DIFF,  C_ALWAYS,    ST_RPT_EMIT, ST_RPT_EMIT};
      ST_RPT_EMIT: w = '{1'b1, OP_RPT_EMIT,  C_IDX_LAST,  ST_IDLE,    ST_RPT_RD};
      default:     w = '{1'b0, OP_LOAD,      C_LOAD_LAST, ST_SCHED,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nonpreemptive_priority_scheduler.sv @@
// Top level of the non-preemptive priority scheduler: microcoded sequencer and datapath.
// Depends on nps_pkg (types, control store) and nps_ram (job and finish stores).
`default_nettype none

// Usage
//   Input transactions (start/busy): a job is taken at an edge with start high and
//   busy low. Jobs load one per cycle while the block is idle; a job beyond MAX_JOBS
//   is dropped. A job with in_last_job set closes the set and starts scheduling,
//   during which busy stays high.
//   Scheduling: every decision pass reads the job store once, one entry per cycle,
//   between a start step and a pick step; a pass that finds no arrived job
//   advances time by one tick. For N stored jobs there are N passes that pick a
//   job plus one per idle tick, and one final pass that finds all jobs done.
//   Reporting: one result per job in load order, each from a read, a difference and
//   an emit step over the single read port of the stores. Each result is shown for
//   one cycle with out_valid high; the receiver cannot stall, so no result is held back.
//   busy drops in the cycle after the last result is registered; the last result
//   (out_last_result high) appears in that same cycle.
//   Reset (rst_n low, synchronous) empties the job set and returns to idle.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_JOBS      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [nps_pkg::ARR_W-1:0]      in_arrival_time,
  input  wire logic [nps_pkg::BURST_W-1:0]    in_burst_time,
  input  wire logic [nps_pkg::PRIO_IN_W-1:0]  in_priority_req,
  input  wire logic                           in_last_job,
  output logic                                out_valid,
  output logic [nps_pkg::JOBNUM_W-1:0]        out_job_number,
  output logic [nps_pkg::TIME_W-1:0]          out_completion_time,
  output logic [nps_pkg::TIME_W-1:0]          out_turnaround_time,
  output logic [nps_pkg::TIME_W-1:0]          out_waiting_time,
  output logic [nps_pkg::TOTAL_W-1:0]         out_total_turnaround,
  output logic [nps_pkg::TOTAL_W-1:0]         out_total_waiting,
  output logic                                out_last_result
);

  localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int TICK_W = $clog2((MAX_JOBS + 1) * (1 << nps_pkg::ARR_W));
  localparam int PS_W   = (PRIORITY_BITS < nps_pkg::PRIO_IN_W) ? PRIORITY_BITS
                                                               : nps_pkg::PRIO_IN_W;
  localparam int JOB_W  = nps_pkg::ARR_W + nps_pkg::BURST_W + PS_W;

  // Sequencer state
  nps_pkg::step_t   step_r, step_nxt;
  nps_pkg::ucode_t  uc;
  logic             take;

  // Datapath registers
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           finished_r, finished_nxt;
  logic [TICK_W-1:0]          tick_r, tick_nxt;
  logic [MAX_JOBS-1:0]        done_r, done_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [nps_pkg::SENT_W-1:0] best_prio_r, best_prio_nxt;
  logic [IDX_W-1:0]           best_idx_r, best_idx_nxt;
  logic [nps_pkg::BURST_W-1:0] best_burst_r, best_burst_nxt;
  logic [TICK_W-1:0]          tat_r, tat_nxt;
  logic [nps_pkg::BURST_W-1:0] rburst_r, rburst_nxt;
  logic [nps_pkg::TOTAL_W-1:0] tot_tat_r, tot_tat_nxt;
  logic [nps_pkg::TOTAL_W-1:0] tot_wt_r, tot_wt_nxt;

  // Result registers
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [nps_pkg::JOBNUM_W-1:0]  out_jn_r, out_jn_nxt;
  logic [nps_pkg::TIME_W-1:0]    out_ct_r, out_ct_nxt;
  logic [nps_pkg::TIME_W-1:0]    out_tat_r, out_tat_nxt;
  logic [nps_pkg::TIME_W-1:0]    out_wt_r, out_wt_nxt;
  logic [nps_pkg::TOTAL_W-1:0]   out_ttat_r, out_ttat_nxt;
  logic [nps_pkg::TOTAL_W-1:0]   out_twt_r, out_twt_nxt;

  // Store ports
  logic                job_we, fin_we;
  logic [IDX_W-1:0]    raddr;
  logic [JOB_W-1:0]    job_wdata, job_rdata;
  logic [TICK_W-1:0]   fin_wdata, fin_rdata;

  // Decoded store data and helpers
  logic                        accept;
  logic                        idx_last;
  logic                        eligible;
  logic [nps_pkg::ARR_W-1:0]   rd_arr;
  logic [nps_pkg::BURST_W-1:0] rd_burst;
  logic [PS_W-1:0]             rd_prio;
  logic [TICK_W-1:0]           arr_ext;
  logic [TICK_W-1:0]           wt_full;
  logic [TICK_W+nps_pkg::TOTAL_W-1:0] fin_wide, tat_wide, wt_wide;
  logic [IDX_W+nps_pkg::JOBNUM_W:0]   jn_wide;

  assign accept   = start && !busy;
  assign idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign rd_arr   = job_rdata[JOB_W-1 -: nps_pkg::ARR_W];
  assign rd_burst = job_rdata[PS_W+nps_pkg::BURST_W-1 -: nps_pkg::BURST_W];
  assign rd_prio  = job_rdata[PS_W-1:0];
  assign arr_ext  = TICK_W'(rd_arr);

  assign job_wdata = {in_arrival_time, in_burst_time, in_priority_req[PS_W-1:0]};
  assign fin_wdata = tick_r + TICK_W'(best_burst_r);

  // Candidate test for the entry read this cycle
  assign eligible = !done_r[idx_r] && (arr_ext <= tick_r) &&
                    (nps_pkg::SENT_W'(rd_prio) < best_prio_r);

  // Report arithmetic, widened then cut to the field widths
  assign wt_full  = tat_r - TICK_W'(rburst_r);
  assign fin_wide = {{nps_pkg::TOTAL_W{1'b0}}, fin_rdata};
  assign tat_wide = {{nps_pkg::TOTAL_W{1'b0}}, tat_r};
  assign wt_wide  = {{nps_pkg::TOTAL_W{1'b0}}, wt_full};
  assign jn_wide  = {{(nps_pkg::JOBNUM_W+1){1'b0}}, idx_r} +
                    (IDX_W+nps_pkg::JOBNUM_W+1)'(1);

  // Job store: arrival, burst, priority packed in one word
  nps_ram #(
    .WIDTH(JOB_W),
    .DEPTH(MAX_JOBS)
  ) u_job_ram (
    .clk  (clk),
    .we   (job_we),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(job_wdata),
    .raddr(raddr),
    .rdata(job_rdata)
  );

  // Finish-time store
  nps_ram #(
    .WIDTH(TICK_W),
    .DEPTH(MAX_JOBS)
  ) u_fin_ram (
    .clk  (clk),
    .we   (fin_we),
    .waddr(best_idx_r),
    .wdata(fin_wdata),
    .raddr(raddr),
    .rdata(fin_rdata)
  );

  // Sequencer and datapath control
  always_comb begin
    uc   = nps_pkg::ucode_rom(step_r);
    busy = uc.busy;

    case (uc.cond)
      nps_pkg::C_ALWAYS:    take = 1'b1;
      nps_pkg::C_LOAD_LAST: take = accept && in_last_job;
      nps_pkg::C_ALL_DONE:  take = (finished_r == count_r);
      nps_pkg::C_IDX_LAST:  take = idx_last;
      default:              take = 1'b0;
    endcase
    step_nxt = take ? uc.jmp_taken : uc.jmp_else;

    count_nxt      = count_r;
    finished_nxt   = finished_r;
    tick_nxt       = tick_r;
    done_nxt       = done_r;
    idx_nxt        = idx_r;
    best_prio_nxt  = best_prio_r;
    best_idx_nxt   = best_idx_r;
    best_burst_nxt = best_burst_r;
    tat_nxt        = tat_r;
    rburst_nxt     = rburst_r;
    tot_tat_nxt    = tot_tat_r;
    tot_wt_nxt     = tot_wt_r;
    out_valid_nxt  = 1'b0;
    out_last_nxt   = 1'b0;
    out_jn_nxt     = out_jn_r;
    out_ct_nxt     = out_ct_r;
    out_tat_nxt    = out_tat_r;
    out_wt_nxt     = out_wt_r;
    out_ttat_nxt   = out_ttat_r;
    out_twt_nxt    = out_twt_r;
    job_we         = 1'b0;
    fin_we         = 1'b0;
    raddr          = idx_r;

    case (uc.op)
      // Take a job into the next free entry
      nps_pkg::OP_LOAD: begin
        if (accept && (count_r < CNT_W'(MAX_JOBS))) begin
          job_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      // Start a decision pass
      nps_pkg::OP_SCAN_INIT: begin
        raddr         = '0;
        idx_nxt       = '0;
        best_prio_nxt = nps_pkg::PRIO_SENTINEL;
      end
      // One entry per cycle, first minimum wins
      nps_pkg::OP_SCAN: begin
        raddr = idx_r + IDX_W'(1);
        if (eligible) begin
          best_prio_nxt  = nps_pkg::SENT_W'(rd_prio);
          best_idx_nxt   = idx_r;
          best_burst_nxt = rd_burst;
        end
        if (!idx_last) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      // Run the chosen job to completion, or let one tick go by
      nps_pkg::OP_PICK: begin
        if (best_prio_r != nps_pkg::PRIO_SENTINEL) begin
          fin_we                 = 1'b1;
          tick_nxt               = fin_wdata;
          done_nxt[best_idx_r]   = 1'b1;
          finished_nxt           = finished_r + CNT_W'(1);
        end else begin
          tick_nxt = tick_r + TICK_W'(1);
        end
      end
      nps_pkg::OP_RPT_RD: begin
        raddr = idx_r;
      end
      // Turnaround from the stored finish and arrival
      nps_pkg::OP_RPT_DIFF: begin
        tat_nxt    = fin_rdata - arr_ext;
        rburst_nxt = rd_burst;
      end
      // Register one result and update the totals
      nps_pkg::OP_RPT_EMIT: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = idx_last;
        out_jn_nxt    = jn_wide[nps_pkg::JOBNUM_W-1:0];
        out_ct_nxt    = fin_wide[nps_pkg::TIME_W-1:0];
        out_tat_nxt   = tat_wide[nps_pkg::TIME_W-1:0];
        out_wt_nxt    = wt_wide[nps_pkg::TIME_W-1:0];
        out_ttat_nxt  = tot_tat_r + tat_wide[nps_pkg::TOTAL_W-1:0];
        out_twt_nxt   = tot_wt_r + wt_wide[nps_pkg::TOTAL_W-1:0];
        tot_tat_nxt   = out_ttat_nxt;
        tot_wt_nxt    = out_twt_nxt;
        if (idx_last) begin
          count_nxt    = '0;
          finished_nxt = '0;
          tick_nxt     = '0;
          done_nxt     = '0;
          tot_tat_nxt  = '0;
          tot_wt_nxt   = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        raddr = idx_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= nps_pkg::ST_IDLE;
      count_r     <= '0;
      finished_r  <= '0;
      tick_r      <= '0;
      done_r      <= '0;
      idx_r       <= '0;
      tot_tat_r   <= '0;
      tot_wt_r    <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      finished_r  <= finished_nxt;
      tick_r      <= tick_nxt;
      done_r      <= done_nxt;
      idx_r       <= idx_nxt;
      tot_tat_r   <= tot_tat_nxt;
      tot_wt_r    <= tot_wt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    best_prio_r  <= best_prio_nxt;
    best_idx_r   <= best_idx_nxt;
    best_burst_r <= best_burst_nxt;
    tat_r        <= tat_nxt;
    rburst_r     <= rburst_nxt;
    out_jn_r     <= out_jn_nxt;
    out_ct_r     <= out_ct_nxt;
    out_tat_r    <= out_tat_nxt;
    out_wt_r     <= out_wt_nxt;
    out_ttat_r   <= out_ttat_nxt;
    out_twt_r    <= out_twt_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_last_result      = out_last_r;
  assign out_job_number       = out_jn_r;
  assign out_completion_time  = out_ct_r;
  assign out_turnaround_time  = out_tat_r;
  assign out_waiting_time     = out_wt_r;
  assign out_total_turnaround = out_ttat_r;
  assign out_total_waiting    = out_twt_r;

  // Checks
  a_fin_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r <= count_r)
    else $error("finished count above job count");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result without a scheduling run");

  a_last_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last flag without result strobe");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (!busy && (count_r == '0)))
    else $error("set not cleared after last result");

endmodule

`default_nettype wire

@@ hw/rtl/nps_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
